// ===== hw/rtl/assert_macros.svh =====
// Assertion macros shared by the checker files of this block.
// Depends on nothing; every use supplies its own clock, reset and message.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every clock edge outside reset.
`define ASSERT_CLK(name, clk, rst_n, prop, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Property checked only at edges where a qualifier holds.
`define ASSERT_WHEN(name, clk, rst_n, qual, prop, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (qual) |-> (prop)) \
		else $error(msg);

`endif

// ===== hw/rtl/gmpc_pkg.sv =====
// Shared types and constants of the grid max path score counter.
// Used by the cell, the core and the checker; depends on nothing.
package gmpc_pkg;

	// Geometry of one grid row and the line buffer that holds it.
	localparam int MAX_COLS = 128;
	localparam int COL_W    = $clog2(MAX_COLS);
	localparam int LEN_W    = 8;

	// Field widths of the transactions.
	localparam int KIND_W  = 2;
	localparam int DIGIT_W = 4;
	localparam int SCORE_W = 12;
	localparam int COUNT_W = 30;
	localparam int PATH_W  = SCORE_W + COUNT_W;

	// Arithmetic limits.
	localparam logic [COUNT_W-1:0] PRIME     = 30'd1000000007;
	localparam logic [SCORE_W-1:0] SCORE_MAX = '1;
	localparam logic [DIGIT_W-1:0] DIGIT_MAX = 4'd9;

	// Cell kind codes.
	localparam logic [KIND_W-1:0] KIND_OBSTACLE = 2'd0;
	localparam logic [KIND_W-1:0] KIND_DIGIT    = 2'd1;
	localparam logic [KIND_W-1:0] KIND_START    = 2'd2;
	localparam logic [KIND_W-1:0] KIND_END      = 2'd3;

	// Register port: byte address bits and register index codes.
	localparam int PADDR_W = 3;
	localparam int PDATA_W = 32;
	localparam logic [PADDR_W-3:0] REG_ROW_LENGTH   = '0;
	localparam logic [LEN_W-1:0]   ROW_LENGTH_RESET = 8'd128;

	// Score and count of a path end; a zero count means unreachable.
	typedef struct packed {
		logic [SCORE_W-1:0] score;
		logic [COUNT_W-1:0] count;
	} path_t;

endpackage

// ===== hw/rtl/gmpc_ram.sv =====
// Generic single-port-write, single-port-read RAM with a registered read.
// Depends on nothing; width and depth come from parameters.
module gmpc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	// A read of the address being written returns the old contents.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// ===== hw/rtl/gmpc_cell.sv =====
// One link of the neighbor comparison chain: merges one candidate path into the best so far.
// Depends on gmpc_pkg for the path type and the modulus.
module gmpc_cell (
	input  logic           en,
	input  gmpc_pkg::path_t cand,
	input  gmpc_pkg::path_t best_in,
	output gmpc_pkg::path_t best_out
);

	logic [gmpc_pkg::COUNT_W:0] sum;
	logic [gmpc_pkg::COUNT_W:0] sum_red;

	// Tied counts add modulo the prime; both operands are below it.
	assign sum     = {1'b0, best_in.count} + {1'b0, cand.count};
	assign sum_red = (sum >= {1'b0, gmpc_pkg::PRIME}) ? sum - {1'b0, gmpc_pkg::PRIME} : sum;

	// A candidate with no paths is ignored; a higher score wins, a tie accumulates.
	always_comb begin
		best_out = best_in;
		if (en && cand.count != '0) begin
			if (best_in.count == '0 || cand.score > best_in.score) begin
				best_out = cand;
			end else if (cand.score == best_in.score) begin
				best_out.count = sum_red[gmpc_pkg::COUNT_W-1:0];
			end
		end
	end

endmodule

// ===== hw/rtl/grid_max_path_score_counter_core.sv =====
// Grid max path score counter: takes grid cells in reverse raster order, one per transaction,
// and returns for each the best path score from the start and the number of such paths modulo
// 1000000007. A cell is taken every clock cycle while in_stall is low. An accepted cell waits in
// stage one for the registered read of the 128-entry row line buffer; its result then passes the
// three-link neighbor comparison chain into the output register and straight on to the next cell.
// The line buffer needs no clearing after reset. The row length register sits at byte address 0.
module grid_max_path_score_counter_core (
	input  logic                           clk,
	input  logic                           arst_n,
	// Register port.
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [gmpc_pkg::PADDR_W-1:0]   paddr,
	input  logic [gmpc_pkg::PDATA_W-1:0]   pwdata,
	output logic [gmpc_pkg::PDATA_W-1:0]   prdata,
	output logic                           pready,
	// Cell input channel.
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [gmpc_pkg::KIND_W-1:0]    cell_kind,
	input  logic [gmpc_pkg::DIGIT_W-1:0]   cell_digit,
	input  logic                           first_cell,
	// Result channel.
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [gmpc_pkg::SCORE_W-1:0]   best_score,
	output logic [gmpc_pkg::COUNT_W-1:0]   path_count,
	output logic                           reachable
);

	localparam int NUM_CAND = 3;
	localparam int CAND_DIAG  = 0;
	localparam int CAND_LOW   = 1;
	localparam int CAND_RIGHT = 2;

	// Configuration and row position state.
	logic [gmpc_pkg::LEN_W-1:0] row_length_q;
	logic [gmpc_pkg::COL_W-1:0] col_q;
	logic                       first_row_q;

	// Stage one: accepted cell waiting for its line buffer data.
	logic                         valid_s1;
	logic [gmpc_pkg::KIND_W-1:0]  kind_s1;
	logic [gmpc_pkg::DIGIT_W-1:0] digit_s1;
	logic [gmpc_pkg::COL_W-1:0]   col_s1;
	logic                         first_row_s1;
	logic                         fwd_s1;

	// Neighbor registers and the output register.
	gmpc_pkg::path_t right_q;
	gmpc_pkg::path_t diag_q;
	gmpc_pkg::path_t out_q;
	logic            out_valid_q;

	logic                         cfg_wr;
	logic                         cfg_hit;
	logic                         in_acc;
	logic                         s1_adv;
	logic [gmpc_pkg::LEN_W-1:0]   len_eff;
	logic [gmpc_pkg::COL_W-1:0]   col_in;
	logic [gmpc_pkg::LEN_W-1:0]   col_next;
	logic [gmpc_pkg::DIGIT_W-1:0] digit_in;
	logic [gmpc_pkg::PATH_W-1:0]  ram_rd;
	gmpc_pkg::path_t              low;
	gmpc_pkg::path_t              res;
	gmpc_pkg::path_t              best;
	logic [gmpc_pkg::SCORE_W:0]   score_sum;
	gmpc_pkg::path_t              cand  [NUM_CAND];
	logic                         cand_en [NUM_CAND];
	gmpc_pkg::path_t              chain [NUM_CAND+1];

	// Register port decode; writes complete in the access phase.
	assign pready  = 1'b1;
	assign cfg_wr  = psel & penable & pwrite;
	assign cfg_hit = (paddr[gmpc_pkg::PADDR_W-1:2] == gmpc_pkg::REG_ROW_LENGTH);
	assign prdata  = cfg_hit ? gmpc_pkg::PDATA_W'(row_length_q) : '0;

	// Handshake: stage one moves on when the output register is free or being emptied.
	assign s1_adv   = valid_s1 & (~out_valid_q | ~out_stall);
	assign in_stall = valid_s1 & ~s1_adv;
	assign in_acc   = in_valid & ~in_stall;

	// Row length clamped to the line buffer size, and the column of the incoming cell.
	always_comb begin
		len_eff = row_length_q;
		if (row_length_q == '0) begin
			len_eff = gmpc_pkg::LEN_W'(1);
		end else if (row_length_q > gmpc_pkg::LEN_W'(gmpc_pkg::MAX_COLS)) begin
			len_eff = gmpc_pkg::LEN_W'(gmpc_pkg::MAX_COLS);
		end
	end

	assign col_in   = first_cell ? '0 : col_q;
	assign col_next = gmpc_pkg::LEN_W'(col_in) + gmpc_pkg::LEN_W'(1);
	assign digit_in = (cell_digit > gmpc_pkg::DIGIT_MAX) ? gmpc_pkg::DIGIT_MAX : cell_digit;

	// Configuration register, updated on register writes, and row position, updated per accepted transaction.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_length_q <= gmpc_pkg::ROW_LENGTH_RESET;
			col_q        <= '0;
			first_row_q  <= 1'b1;
		end else begin
			if (cfg_wr && cfg_hit) begin
				row_length_q <= pwdata[gmpc_pkg::LEN_W-1:0];
			end
			if (in_acc) begin
				if (col_next >= len_eff) begin
					col_q       <= '0;
					first_row_q <= 1'b0;
				end else begin
					col_q       <= col_next[gmpc_pkg::COL_W-1:0];
					first_row_q <= first_cell | first_row_q;
				end
			end
		end
	end

	// Control of stage one, the neighbor registers and the output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
			right_q     <= '0;
			diag_q      <= '0;
		end else begin
			if (in_acc) begin
				valid_s1 <= 1'b1;
			end else if (s1_adv) begin
				valid_s1 <= 1'b0;
			end
			if (s1_adv) begin
				out_valid_q <= 1'b1;
				right_q     <= res;
				diag_q      <= low;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers; the forward flag marks a read of the entry written in the same cycle.
	always_ff @(posedge clk) begin
		if (in_acc) begin
			kind_s1      <= cell_kind;
			digit_s1     <= digit_in;
			col_s1       <= col_in;
			first_row_s1 <= first_cell | first_row_q;
			fwd_s1       <= s1_adv && (col_s1 == col_in);
		end
		if (s1_adv) begin
			out_q <= res;
		end
	end

	// Previous row line buffer.
	gmpc_ram #(
		.WIDTH(gmpc_pkg::PATH_W),
		.DEPTH(gmpc_pkg::MAX_COLS)
	) u_row_buf (
		.clk    (clk),
		.wr_en  (s1_adv),
		.wr_addr(col_s1),
		.wr_data(res),
		.rd_en  (in_acc),
		.rd_addr(col_in),
		.rd_data(ram_rd)
	);

	// Lower neighbor, taken from the last result when it was written in the read cycle.
	assign low = fwd_s1 ? right_q : gmpc_pkg::path_t'(ram_rd);

	// Candidate neighbors and the conditions under which each one exists.
	always_comb begin
		cand[CAND_DIAG]     = diag_q;
		cand[CAND_LOW]      = low;
		cand[CAND_RIGHT]    = right_q;
		cand_en[CAND_DIAG]  = (col_s1 != '0) & ~first_row_s1;
		cand_en[CAND_LOW]   = ~first_row_s1;
		cand_en[CAND_RIGHT] = (col_s1 != '0);
	end

	// Comparison chain: each cell folds one neighbor into the running best.
	assign chain[0] = '0;
	for (genvar i = 0; i < NUM_CAND; i++) begin : g_chain
		gmpc_cell u_cell (
			.en      (cand_en[i]),
			.cand    (cand[i]),
			.best_in (chain[i]),
			.best_out(chain[i+1])
		);
	end
	assign best = chain[NUM_CAND];

	// Result by cell kind; digit cells add their saturated score.
	assign score_sum = {1'b0, best.score} + (gmpc_pkg::SCORE_W+1)'(digit_s1);

	always_comb begin
		res = '0;
		case (kind_s1)
			gmpc_pkg::KIND_START: begin
				res.count = gmpc_pkg::COUNT_W'(1);
			end
			gmpc_pkg::KIND_OBSTACLE: begin
				res = '0;
			end
			gmpc_pkg::KIND_DIGIT: begin
				if (best.count != '0) begin
					res.count = best.count;
					res.score = score_sum[gmpc_pkg::SCORE_W] ? gmpc_pkg::SCORE_MAX
						: score_sum[gmpc_pkg::SCORE_W-1:0];
				end
			end
			gmpc_pkg::KIND_END: begin
				if (best.count != '0) begin
					res = best;
				end
			end
			default: begin
				res = '0;
			end
		endcase
	end

	// Result port.
	assign out_valid  = out_valid_q;
	assign best_score = out_q.score;
	assign path_count = out_q.count;
	assign reachable  = (out_q.count != '0);

endmodule

// ===== hw/rtl/gmpc_checker.sv =====
// Port-level checker of the grid max path score counter, bound to the core.
// Depends on gmpc_pkg and on the macros in assert_macros.svh.
`include "assert_macros.svh"

module gmpc_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           in_valid,
	input logic                           in_stall,
	input logic                           out_valid,
	input logic                           out_stall,
	input logic [gmpc_pkg::SCORE_W-1:0]   best_score,
	input logic [gmpc_pkg::COUNT_W-1:0]   path_count,
	input logic                           reachable
);

	// An unreachable result carries a zero score, and reachable tracks a non-zero count.
	`ASSERT_WHEN(a_unreach_zero, clk, arst_n, out_valid && !reachable, best_score == '0 && path_count == '0, "unreachable result with nonzero score or count")

	// Path counts stay reduced modulo the prime.
	`ASSERT_WHEN(a_count_reduced, clk, arst_n, out_valid, path_count < gmpc_pkg::PRIME, "path count not reduced modulo the prime")

	// An accepted transaction yields a valid output when the output is not stalled after acceptance.
	`ASSERT_CLK(a_latency, clk, arst_n, (in_valid && !in_stall) ##1 !out_stall |=> out_valid, "accepted transaction did not reach the output")

	// A stalled result holds.
	`ASSERT_CLK(a_out_hold, clk, arst_n, out_valid && out_stall |=> out_valid && $stable(path_count) && $stable(best_score), "stalled result changed")

endmodule

bind grid_max_path_score_counter_core gmpc_checker u_gmpc_checker (.*);

// ===== sim/path_score_checker.sv =====
`timescale 1ns / 1ps
// Checker for the grid max path score counter: tracks register writes and cell transactions,
// predicts each cell's best score and path count, and compares them with the results.
// Depends on gmpc_pkg for field widths, cell kind codes and the path type.
module path_score_checker
	import gmpc_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic               pready,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	input  logic               in_valid,
	input  logic               in_stall,
	input  logic [KIND_W-1:0]  cell_kind,
	input  logic [DIGIT_W-1:0] cell_digit,
	input  logic               first_cell,
	input  logic               out_valid,
	input  logic               out_stall,
	input  logic [SCORE_W-1:0] best_score,
	input  logic [COUNT_W-1:0] path_count,
	input  logic               reachable,
	output int                 mismatches,
	output int                 outstanding
);

	// Shadow of the block's state: previous row, right and diagonal neighbors, position.
	path_t            prev_row [MAX_COLS];
	path_t            right_path;
	path_t            diag_path;
	logic [COL_W-1:0] col_pos;
	logic             top_row;
	logic [LEN_W-1:0] row_len;

	// Predicted results in transaction order.
	path_t expected_paths [$];
	int    errors = 0;

	// Folds one neighbor into the running best; a zero count means unreachable.
	function automatic path_t merge_path(input path_t acc, input path_t cand);
		logic [COUNT_W:0] sum;
		if (cand.count == '0)
			return acc;
		if (acc.count == '0 || cand.score > acc.score)
			return cand;
		if (cand.score == acc.score) begin
			sum = acc.count + cand.count;
			if (sum >= PRIME)
				sum = sum - PRIME;
			acc.count = sum[COUNT_W-1:0];
		end
		return acc;
	endfunction

	// Scores one cell and advances the shadow state past it.
	function automatic path_t score_cell(input logic [KIND_W-1:0] kind,
			input logic [DIGIT_W-1:0] digit, input logic first_flag);
		int                 eff;
		logic [DIGIT_W-1:0] clip;
		logic [COL_W-1:0]   col;
		logic [SCORE_W:0]   total;
		path_t              lower;
		path_t              best;
		eff = (row_len == 0) ? 1 : ((row_len > MAX_COLS) ? MAX_COLS : int'(row_len));
		clip = (digit > DIGIT_MAX) ? DIGIT_MAX : digit;
		if (first_flag) begin
			col_pos = '0;
			top_row = 1'b1;
		end
		col = col_pos;
		lower = prev_row[col];
		best = '0;
		if (kind == KIND_START) begin
			best.count = 1;
		end else if (kind != KIND_OBSTACLE) begin
			if (col != 0)
				best = merge_path(best, right_path);
			if (!top_row) begin
				best = merge_path(best, lower);
				if (col != 0)
					best = merge_path(best, diag_path);
			end
			if (best.count == '0) begin
				best.score = '0;
			end else if (kind == KIND_DIGIT) begin
				total = best.score + clip;
				best.score = (total > SCORE_MAX) ? SCORE_MAX : total[SCORE_W-1:0];
			end
		end
		diag_path = lower;
		prev_row[col] = best;
		right_path = best;
		if (int'(col) + 1 >= eff) begin
			col_pos = '0;
			top_row = 1'b0;
		end else begin
			col_pos = col + 1'b1;
		end
		return best;
	endfunction

	// Follow register writes and transactions on both channels.
	always @(posedge clk or negedge arst_n) begin : watch
		path_t want;
		if (!arst_n) begin
			for (int i = 0; i < MAX_COLS; i++)
				prev_row[i] = '0;
			right_path = '0;
			diag_path = '0;
			col_pos = '0;
			top_row = 1'b1;
			row_len = ROW_LENGTH_RESET;
			expected_paths.delete();
			outstanding <= 0;
			mismatches <= errors;
		end else begin
			// Register write completes in the access cycle.
			if (psel && penable && pwrite && pready && paddr[PADDR_W-1:2] == REG_ROW_LENGTH)
				row_len = pwdata[LEN_W-1:0];

			// Accepted cell transaction: predict its result.
			if (in_valid && !in_stall)
				expected_paths.push_back(score_cell(cell_kind, cell_digit, first_cell));

			// Accepted result transaction: compare with the oldest prediction.
			if (out_valid && !out_stall) begin
				if (expected_paths.size() == 0) begin
					errors++;
					if (errors <= 10)
						$display("%0t: unexpected result score %0d count %0d reachable %0b",
							$time, best_score, path_count, reachable);
				end else begin
					want = expected_paths.pop_front();
					if (best_score !== want.score || path_count !== want.count ||
							reachable !== (want.count != '0)) begin
						errors++;
						if (errors <= 10)
							$display("%0t: expected score %0d count %0d reachable %0b, %s %0d %0d %0b",
								$time, want.score, want.count, want.count != '0,
								"got", best_score, path_count, reachable);
					end
				end
			end
			mismatches <= errors;
			outstanding <= expected_paths.size();
		end
	end

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps
// Testbench top for the grid max path score counter: resets the core, writes the row length,
// drives cell transactions with random gaps and stalls, and reports the verdict.
// Depends on gmpc_pkg, grid_max_path_score_counter_core and path_score_checker.
module tb_top;
	import gmpc_pkg::*;

	localparam int CYCLE_LIMIT  = 400000;
	localparam int DRAIN_CYCLES = 4;

	typedef enum {GRID_MIXED, GRID_UNIFORM} grid_style_t;

	logic               clk        = 1'b0;
	logic               arst_n     = 1'b0;
	logic               psel       = 1'b0;
	logic               penable    = 1'b0;
	logic               pwrite     = 1'b0;
	logic [PADDR_W-1:0] paddr      = '0;
	logic [PDATA_W-1:0] pwdata     = '0;
	logic [PDATA_W-1:0] prdata;
	logic               pready;
	logic               in_valid   = 1'b0;
	logic               in_stall;
	logic [KIND_W-1:0]  cell_kind  = KIND_OBSTACLE;
	logic [DIGIT_W-1:0] cell_digit = '0;
	logic               first_cell = 1'b0;
	logic               out_valid;
	logic               out_stall  = 1'b0;
	logic [SCORE_W-1:0] best_score;
	logic [COUNT_W-1:0] path_count;
	logic               reachable;
	int                 mismatches;
	int                 outstanding;

	// Effective row length in force, and whether each side idles in this stretch.
	int cur_width   = MAX_COLS;
	bit tx_throttle = 1'b1;
	bit rx_throttle = 1'b1;

	grid_max_path_score_counter_core uut (.*);
	path_score_checker u_path_check (.*);

	// Clock.
	initial begin
		forever #5 clk = ~clk;
	end

	// Watchdog on the whole run.
	initial begin : watchdog
		int unsigned cycles;
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("Verification failed");
		$finish;
	end

	// Result side: stall for a random number of cycles before each transaction.
	initial begin : drain_results
		int unsigned hold;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			hold = rx_throttle ? $urandom_range(0, 12) : 0;
			if (hold != 0) begin
				out_stall <= 1'b1;
				repeat (hold) @(posedge clk);
			end
			out_stall <= 1'b0;
			do @(posedge clk); while (!(out_valid === 1'b1 && out_stall === 1'b0));
		end
	end

	// One cell transaction, preceded by a random gap or, rarely, by a full drain.
	task automatic send_cell(input logic [KIND_W-1:0] kind, input logic [DIGIT_W-1:0] digit,
			input logic first_flag);
		int unsigned gap;
		gap = tx_throttle ? $urandom_range(0, 12) : 0;
		if ($urandom_range(0, 79) == 0) begin
			in_valid <= 1'b0;
			@(posedge clk);
			while (outstanding != 0) @(posedge clk);
		end else if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid   <= 1'b1;
		cell_kind  <= kind;
		cell_digit <= digit;
		first_cell <= first_flag;
		do @(posedge clk); while (in_stall !== 1'b0);
	endtask

	// Stop sending and wait until every result is out and the pipeline is empty.
	task automatic settle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Register write: setup cycle, then access cycle.
	task automatic write_row_length(input logic [LEN_W-1:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {REG_ROW_LENGTH, 2'b00};
		pwdata  <= {(PDATA_W-LEN_W)'($urandom()), value};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	// Mostly reachable digit cells, with obstacles, end cells, extra starts and new grids.
	task automatic send_mixed(input int digit_hi);
		int                 pick;
		logic [DIGIT_W-1:0] digit;
		pick = $urandom_range(0, 99);
		if ($urandom_range(0, 7) == 0)
			digit = DIGIT_W'($urandom_range(0, 15));
		else
			digit = DIGIT_W'($urandom_range(0, digit_hi));
		if (pick < 72)
			send_cell(KIND_DIGIT, digit, 1'b0);
		else if (pick < 84)
			send_cell(KIND_OBSTACLE, digit, 1'b0);
		else if (pick < 92)
			send_cell(KIND_END, digit, 1'b0);
		else if (pick < 96)
			send_cell(KIND_START, digit, 1'($urandom_range(0, 1)));
		else
			send_cell(KIND_W'($urandom_range(0, 3)), digit, 1'b1);
	endtask

	// Same digit everywhere; a nine is sometimes given as fifteen, a zero as an end cell.
	task automatic send_uniform(input int digit_hi);
		if (digit_hi == 0 && $urandom_range(0, 9) == 0)
			send_cell(KIND_END, DIGIT_W'($urandom_range(0, 15)), 1'b0);
		else if (digit_hi == int'(DIGIT_MAX) && $urandom_range(0, 3) == 0)
			send_cell(KIND_DIGIT, {DIGIT_W{1'b1}}, 1'b0);
		else
			send_cell(KIND_DIGIT, DIGIT_W'(digit_hi), 1'b0);
	endtask

	// One stretch of random cells under a new row length. A longer row always opens a
	// new grid, so that no line buffer entry is read before it has been written.
	task automatic run_grid(input logic [LEN_W-1:0] width_cfg, input int cells,
			input grid_style_t style, input int digit_hi, input bit fresh);
		int eff;
		bit restart;
		settle();
		write_row_length(width_cfg);
		eff = (width_cfg == 0) ? 1 : ((width_cfg > MAX_COLS) ? MAX_COLS : int'(width_cfg));
		restart = fresh || eff > cur_width || $urandom_range(0, 2) != 0;
		cur_width = eff;
		tx_throttle = $urandom_range(0, 3) != 0;
		rx_throttle = $urandom_range(0, 3) != 0;
		for (int n = 0; n < cells; n++) begin
			if (n == 0 && restart)
				send_cell(KIND_START, DIGIT_W'($urandom_range(0, 15)), 1'b1);
			else if (style == GRID_UNIFORM)
				send_uniform(digit_hi);
			else
				send_mixed(digit_hi);
		end
	endtask

	// Reset, directed cells, random grids, verdict.
	initial begin : stimulus
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset row length: start, digit extremes, end, obstacle, a cell cut off by the
		// obstacle, and a second start in the same row.
		send_cell(KIND_START, 4'd15, 1'b1);
		send_cell(KIND_DIGIT, DIGIT_MAX, 1'b0);
		send_cell(KIND_DIGIT, 4'd15, 1'b0);
		send_cell(KIND_END, 4'd7, 1'b0);
		send_cell(KIND_OBSTACLE, 4'd15, 1'b0);
		send_cell(KIND_DIGIT, 4'd4, 1'b0);
		send_cell(KIND_START, 4'd0, 1'b0);
		send_cell(KIND_DIGIT, 4'd0, 1'b0);

		// Row length lowered mid-row: the next cell closes the row, then short rows.
		settle();
		write_row_length(8'd3);
		send_cell(KIND_DIGIT, DIGIT_MAX, 1'b0);
		send_cell(KIND_DIGIT, 4'd1, 1'b0);
		send_cell(KIND_DIGIT, 4'd1, 1'b0);
		send_cell(KIND_END, 4'd10, 1'b0);
		send_cell(KIND_DIGIT, 4'd1, 1'b0);
		send_cell(KIND_DIGIT, 4'd1, 1'b0);
		send_cell(KIND_DIGIT, 4'd1, 1'b0);

		// Row length zero acts as a single column; unreachable below an obstacle.
		settle();
		write_row_length(8'd0);
		send_cell(KIND_START, 4'd3, 1'b1);
		send_cell(KIND_DIGIT, 4'd5, 1'b0);
		send_cell(KIND_OBSTACLE, 4'd0, 1'b0);
		send_cell(KIND_DIGIT, 4'd3, 1'b0);

		// Row length beyond the line buffer acts as the full width.
		settle();
		write_row_length(8'd255);
		send_cell(KIND_START, 4'd8, 1'b1);
		send_cell(KIND_DIGIT, 4'd2, 1'b0);
		send_cell(KIND_OBSTACLE, 4'd6, 1'b0);
		send_cell(KIND_END, 4'd12, 1'b0);
		cur_width = MAX_COLS;

		// Random grids: a single column, a flat grid of zeros whose tied counts wrap the
		// modulus, and full-width rows.
		run_grid(8'd5, 40, GRID_MIXED, 9, 1'b0);
		run_grid(8'd1, 60, GRID_UNIFORM, int'(DIGIT_MAX), 1'b1);
		run_grid(8'd15, 225, GRID_UNIFORM, 0, 1'b1);
		run_grid(8'd2, 30, GRID_MIXED, 3, 1'b0);
		run_grid(8'd200, 140, GRID_MIXED, 9, 1'b0);
		run_grid(LEN_W'($urandom_range(1, MAX_COLS)), 30, GRID_MIXED, $urandom_range(0, 15),
			1'b0);
		run_grid(8'd3, 20, GRID_MIXED, 15, 1'b0);
		run_grid(LEN_W'(MAX_COLS), 30, GRID_MIXED, 9, 1'b0);

		settle();
		if (mismatches == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

// ===== files.f =====
+incdir+hw/rtl
hw/rtl/gmpc_pkg.sv
hw/rtl/gmpc_ram.sv
hw/rtl/gmpc_cell.sv
hw/rtl/grid_max_path_score_counter_core.sv
hw/rtl/gmpc_checker.sv
sim/path_score_checker.sv
sim/tb_top.sv
